// ===== src/mse_pkg.sv =====
// mse_pkg: shared widths and defaults for the merge sort engine
// no dependencies

package mse_pkg;

	localparam int unsigned DATA_W           = 32;
	localparam int unsigned MAX_ELEMENTS_DEF = 64;

	typedef logic signed [DATA_W-1:0] value_t;

endpackage

// ===== src/merge_sort_engine.sv =====
// Merge sort engine: collects a set of signed words, then sorts and emits it ascending.
// Uses mse_pkg for the data width, value type and default capacity.
// Two single-clock memories (element and scratch) with registered reads hold all data.

// A set of n words is written one word per cycle into the element memory. The last word
// starts a stable bottom-up merge sort. It makes ceil(log2 n) passes that ping-pong
// between the two memories. Each pass produces one output entry per visit to ST_READ
// and ST_MERGE, since both runs are read through the registered read ports and then
// compared and written. The emit pass likewise goes through ST_EMIT_RD and ST_EMIT_LD
// for each word, and holds in ST_EMIT_LD while the output register is full. Input is
// refused from the last word until the final sorted word is loaded into the output
// register. Words beyond MAX_ELEMENTS are dropped, and every word of that set is then
// flagged in tuser. There is no clearing pass after reset.

module merge_sort_engine
	import mse_pkg::*;
#(
	parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic              m_tlast,
	output logic              m_tuser    // [0] dropped
);

	localparam int unsigned AW = $clog2(MAX_ELEMENTS);
	localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
	localparam int unsigned SW = CW + 2;

	localparam logic [2:0] ST_LOAD    = 3'd0;
	localparam logic [2:0] ST_PASS    = 3'd1;
	localparam logic [2:0] ST_READ    = 3'd2;
	localparam logic [2:0] ST_MERGE   = 3'd3;
	localparam logic [2:0] ST_EMIT_RD = 3'd4;
	localparam logic [2:0] ST_EMIT_LD = 3'd5;

	value_t mem_a [MAX_ELEMENTS];
	value_t mem_b [MAX_ELEMENTS];

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          src_q;
	logic [SW-1:0] w_q;
	logic [CW-1:0] i_q, j_q, k_q, mid_q, hi_q, e_q;
	value_t        rd0_a_q, rd1_a_q, rd0_b_q, rd1_b_q;

	logic          out_valid_q;
	value_t        out_data_q;
	logic          out_last_q;
	logic          out_drop_q;

	logic          in_fire;
	logic          room;
	logic          out_free;
	logic [AW-1:0] ra0, ra1;
	value_t        rd0, rd1;
	logic          take_left;
	value_t        merge_data;
	logic          wr_a, wr_b;
	logic [AW-1:0] wa_a;
	value_t        wd_a;
	logic [SW-1:0] n_ext;
	logic [SW-1:0] w2;
	logic [SW-1:0] hi_ext;
	logic [SW-1:0] seg_mid, seg_hi, pass_mid, pass_hi;

	assign s_tready = (state_q == ST_LOAD);
	assign in_fire  = s_tvalid && s_tready;
	assign room     = (cnt_q < CW'(MAX_ELEMENTS));
	assign out_free = !out_valid_q || m_tready;

	assign n_ext    = SW'(cnt_q);
	assign w2       = w_q << 1;
	assign hi_ext   = SW'(hi_q);
	assign pass_mid = (w_q < n_ext) ? w_q : n_ext;
	assign pass_hi  = (w2 < n_ext) ? w2 : n_ext;
	assign seg_mid  = ((hi_ext + w_q) < n_ext) ? (hi_ext + w_q) : n_ext;
	assign seg_hi   = ((hi_ext + w2) < n_ext) ? (hi_ext + w2) : n_ext;

	// read address: emit uses port 0 at the emit index
	assign ra0 = (state_q == ST_EMIT_RD || state_q == ST_EMIT_LD) ? e_q[AW-1:0] : i_q[AW-1:0];
	assign ra1 = j_q[AW-1:0];
	assign rd0 = src_q ? rd0_b_q : rd0_a_q;
	assign rd1 = src_q ? rd1_b_q : rd1_a_q;

	// left run wins on ties
	assign take_left  = (i_q < mid_q) && (!(j_q < hi_q) || (rd0 <= rd1));
	assign merge_data = take_left ? rd0 : rd1;

	assign wr_a = (in_fire && room) || (state_q == ST_MERGE && src_q);
	assign wr_b = (state_q == ST_MERGE) && !src_q;
	assign wa_a = (state_q == ST_MERGE) ? k_q[AW-1:0] : cnt_q[AW-1:0];
	assign wd_a = (state_q == ST_MERGE) ? merge_data : value_t'(s_tdata);

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wa_a] <= wd_a;
		end
		rd0_a_q <= mem_a[ra0];
		rd1_a_q <= mem_a[ra1];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[k_q[AW-1:0]] <= merge_data;
		end
		rd0_b_q <= mem_b[ra0];
		rd1_b_q <= mem_b[ra1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			src_q   <= 1'b0;
			w_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			e_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							w_q     <= SW'(1);
							src_q   <= 1'b0;
							state_q <= ST_PASS;
						end
					end
				end
				ST_PASS: begin
					if (w_q >= n_ext) begin
						e_q     <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						i_q     <= '0;
						k_q     <= '0;
						mid_q   <= CW'(pass_mid);
						j_q     <= CW'(pass_mid);
						hi_q    <= CW'(pass_hi);
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (take_left) begin
						i_q <= i_q + CW'(1);
					end else begin
						j_q <= j_q + CW'(1);
					end
					k_q <= k_q + CW'(1);
					if (k_q + CW'(1) == hi_q) begin
						if (hi_q == cnt_q) begin
							w_q     <= w2;
							src_q   <= !src_q;
							state_q <= ST_PASS;
						end else begin
							i_q     <= hi_q;
							mid_q   <= CW'(seg_mid);
							j_q     <= CW'(seg_mid);
							hi_q    <= CW'(seg_hi);
							state_q <= ST_READ;
						end
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					if (out_free) begin
						if (e_q + CW'(1) == cnt_q) begin
							cnt_q   <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							e_q     <= e_q + CW'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT_LD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word register, no reset needed for payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD && out_free) begin
			out_data_q <= rd0;
			out_last_q <= (e_q + CW'(1) == cnt_q);
			out_drop_q <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_drop_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ELEMENTS))
		else $error("element count beyond capacity");

	a_merge_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (k_q < hi_q && i_q <= mid_q && j_q <= hi_q))
		else $error("merge indices outside current run");

	a_merge_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE) |-> (SW'(i_q) + SW'(j_q) == SW'(k_q) + SW'(mid_q)))
		else $error("merge indices out of step");

	a_last_ends_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD && out_free && (e_q + CW'(1) == cnt_q))
		|=> (state_q == ST_LOAD && cnt_q == '0 && m_tvalid && m_tlast))
		else $error("final sorted word did not end the set");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD) |-> (e_q < cnt_q))
		else $error("emit index beyond set size");

endmodule
